// ===== rtl/vtdi_pkg.sv =====
// Shared types and constants for the vertex triple dedup indexer.
package vtdi_pkg;

    localparam int MaxVertices = 1024;
    localparam int IndexBits   = 16;
    localparam int SlotBits    = 10;
    localparam int AddrBits    = $clog2(MaxVertices);
    localparam int CountBits   = AddrBits + 1;

    typedef logic [IndexBits-1:0] index_t;
    typedef logic [AddrBits-1:0]  addr_t;
    typedef logic [CountBits-1:0] count_t;
    typedef logic [SlotBits-1:0]  slot_t;

    typedef struct packed {
        index_t pos;
        index_t tex;
        index_t nrm;
    } triple_t;

    // Access request from the sequencer to the table memory.
    typedef struct packed {
        logic    we;
        addr_t   waddr;
        triple_t wdata;
        logic    re;
        addr_t   raddr;
    } tbl_req_t;

    typedef struct packed {
        slot_t slot;
        logic  was_new;
        logic  overflow;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/vtdi_table.sv =====
// Triple table memory: one write port and one registered read port.
module vtdi_table (
    input  logic              clk,
    input  vtdi_pkg::tbl_req_t req,
    output vtdi_pkg::triple_t  rd_data
);

    vtdi_pkg::triple_t mem [vtdi_pkg::MaxVertices];
    vtdi_pkg::triple_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/vtdi_ctrl.sv =====
// Search sequencer: scans the table in insertion order with one shared comparator.
module vtdi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vtdi_pkg::triple_t  in_key,
    input  logic               start_new_mesh,
    output vtdi_pkg::tbl_req_t req,
    input  vtdi_pkg::triple_t  rd_data,
    output logic               res_valid,
    input  logic               res_ready,
    output vtdi_pkg::result_t  res
);

    vtdi_pkg::state_t  state_reg, state_next;
    vtdi_pkg::count_t  ptr_reg, ptr_next;
    vtdi_pkg::count_t  count_reg, count_next;
    logic              cmp_valid_reg, cmp_valid_next;
    vtdi_pkg::addr_t   cmp_addr_reg, cmp_addr_next;
    vtdi_pkg::triple_t key_reg, key_next;
    vtdi_pkg::result_t res_reg, res_next;
    logic              hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vtdi_pkg::ST_IDLE;
            ptr_reg       <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_addr_reg <= cmp_addr_next;
        key_reg      <= key_next;
        res_reg      <= res_next;
    end

    // The read issued last cycle has its data now; compare it against the key.
    assign hit = cmp_valid_reg && (rd_data == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        cmp_valid_next = 1'b0;
        cmp_addr_next  = cmp_addr_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        req            = '0;
        req.wdata      = key_reg;
        req.waddr      = count_reg[vtdi_pkg::AddrBits-1:0];
        req.raddr      = ptr_reg[vtdi_pkg::AddrBits-1:0];
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            vtdi_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    key_next   = in_key;
                    ptr_next   = '0;
                    state_next = vtdi_pkg::ST_SCAN;
                    if (start_new_mesh)
                    begin
                        count_next = '0;
                    end
                end
            end
            vtdi_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    res_next.slot     = vtdi_pkg::SlotBits'(cmp_addr_reg);
                    res_next.was_new  = 1'b0;
                    res_next.overflow = 1'b0;
                    state_next        = vtdi_pkg::ST_DONE;
                end
                else if (ptr_reg < count_reg)
                begin
                    req.re         = 1'b1;
                    ptr_next       = ptr_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_addr_next  = ptr_reg[vtdi_pkg::AddrBits-1:0];
                end
                else
                begin
                    // Every stored entry has been compared without a match.
                    state_next = vtdi_pkg::ST_DONE;
                    if (count_reg == vtdi_pkg::CountBits'(vtdi_pkg::MaxVertices))
                    begin
                        res_next.slot     = '0;
                        res_next.was_new  = 1'b0;
                        res_next.overflow = 1'b1;
                    end
                    else
                    begin
                        req.we            = 1'b1;
                        count_next        = count_reg + 1'b1;
                        res_next.slot     =
                            vtdi_pkg::SlotBits'(count_reg[vtdi_pkg::AddrBits-1:0]);
                        res_next.was_new  = 1'b1;
                        res_next.overflow = 1'b0;
                    end
                end
            end
            vtdi_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = vtdi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vtdi_pkg::ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= vtdi_pkg::CountBits'(vtdi_pkg::MaxVertices))
        else $error("entry count beyond table depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.overflow) |-> (count_reg == vtdi_pkg::CountBits'(vtdi_pkg::MaxVertices)))
        else $error("overflow reported with room left in the table");

    a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not advance the entry count");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.was_new && res.overflow))
        else $error("new entry and overflow flagged together");

    a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vtdi_pkg::ST_SCAN) |-> (ptr_reg <= count_reg))
        else $error("search pointer ran past the entry count");

endmodule

// ===== rtl/vertex_triple_dedup_indexer_core.sv =====
// Top level of the vertex triple dedup indexer: table, sequencer and output register.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word per face corner: the
//   position, texcoord and normal indices plus start_new_mesh, which empties
//   the table before that word is looked up. Output channel (out_valid/
//   out_ready) returns one word per input: the vertex slot, was_new and
//   table_overflow.
//   A miss is compared against every stored entry and a hit stops at its
//   slot; either way the result goes through the output register to
//   out_valid. The next word is accepted only once the sequencer has handed
//   its result to the output register. The memory has one read port, so
//   the search compares one stored entry per cycle, one item at a time.
//   Reset empties the table (the entry count goes to zero) and clears both
//   valid flags; the memory itself is not cleared and needs no clearing pass.
//   When the receiver stalls, the result waits in the output register; the
//   next item is still accepted and searched, and it holds its own result
//   until the output register is free.
module vertex_triple_dedup_indexer_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [15:0]            position_index,
    input  logic [15:0]            texcoord_index,
    input  logic [15:0]            normal_index,
    input  logic                   start_new_mesh,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [9:0]             vertex_slot,
    output logic                   was_new,
    output logic                   table_overflow
);

    vtdi_pkg::triple_t  in_key;
    vtdi_pkg::tbl_req_t req;
    vtdi_pkg::triple_t  rd_data;
    vtdi_pkg::result_t  res;
    logic               res_valid;
    logic               res_ready;
    logic               out_valid_reg, out_valid_next;
    vtdi_pkg::result_t  out_reg, out_next;

    assign in_key.pos = vtdi_pkg::IndexBits'(position_index);
    assign in_key.tex = vtdi_pkg::IndexBits'(texcoord_index);
    assign in_key.nrm = vtdi_pkg::IndexBits'(normal_index);

    vtdi_table u_table (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    vtdi_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_key         (in_key),
        .start_new_mesh (start_new_mesh),
        .req            (req),
        .rd_data        (rd_data),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    // The output register loads when it is empty or its word is taken this cycle.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign vertex_slot    = out_reg.slot;
    assign was_new        = out_reg.was_new;
    assign table_overflow = out_reg.overflow;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the vertex triple dedup indexer core.
module tb_top;

    typedef struct {
        vtdi_pkg::triple_t corner;
        logic              fresh;
        logic              drain;
        logic              burst;
    } corner_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [15:0] position_index = '0;
    logic [15:0] texcoord_index = '0;
    logic [15:0] normal_index = '0;
    logic       start_new_mesh = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [9:0] vertex_slot;
    logic       was_new;
    logic       table_overflow;

    corner_word_t      corner_queue[$];
    vtdi_pkg::result_t slot_expect_q[$];

    // Private copy of the dedup table, advanced once per accepted word.
    vtdi_pkg::triple_t seen_triples [vtdi_pkg::MaxVertices];
    int      seen_count = 0;

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    int   results_seen = 0;
    int   mismatch_count = 0;
    int   send_gap = 0;
    int   rx_wait = 0;
    int   rx_mode_left = 0;
    logic rx_calm = 1'b0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    vertex_triple_dedup_indexer_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .position_index (position_index),
        .texcoord_index (texcoord_index),
        .normal_index   (normal_index),
        .start_new_mesh (start_new_mesh),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .vertex_slot    (vertex_slot),
        .was_new        (was_new),
        .table_overflow (table_overflow)
    );

    always #5 clk = ~clk;

    function automatic vtdi_pkg::result_t predict_corner(vtdi_pkg::triple_t tr, logic fresh);
        vtdi_pkg::result_t r;
        r = '{slot: '0, was_new: 1'b0, overflow: 1'b0};
        if (fresh)
        begin
            seen_count = 0;
        end
        for (int k = 0; k < seen_count; k++)
        begin
            if (seen_triples[k] == tr)
            begin
                r.slot = vtdi_pkg::slot_t'(k);
                return r;
            end
        end
        if (seen_count >= vtdi_pkg::MaxVertices)
        begin
            r.overflow = 1'b1;
            return r;
        end
        seen_triples[seen_count] = tr;
        r.slot = vtdi_pkg::slot_t'(seen_count);
        r.was_new = 1'b1;
        seen_count++;
        return r;
    endfunction

    task automatic push_corner(vtdi_pkg::triple_t tr, logic fresh, logic drain, logic burst);
        corner_word_t w;
        w.corner = tr;
        w.fresh = fresh;
        w.drain = drain;
        w.burst = burst;
        corner_queue.insert(corner_queue.size(), w);
    endtask

    // Sender: a drain word waits until every expected result has come back.
    always @(negedge clk)
    begin
        corner_word_t nxt;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (corner_queue.size() != 0 &&
                     !(corner_queue[0].drain && slot_expect_q.size() != 0))
            begin
                nxt = corner_queue.pop_front();
                in_valid <= 1'b1;
                position_index <= nxt.corner.pos;
                texcoord_index <= nxt.corner.tex;
                normal_index <= nxt.corner.nrm;
                start_new_mesh <= nxt.fresh;
                send_gap <= nxt.burst ? 0 : $urandom_range(0, 13);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random waits per result, calm stretches, and one long hold-off.
    always @(negedge clk)
    begin
        int w;
        if (rst_n)
        begin
            if (!hold_done && results_seen >= 60)
            begin
                hold_done <= 1'b1;
                hold_left <= 400;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (out_taken)
            begin
                if (rx_mode_left == 0)
                begin
                    rx_calm <= ($urandom_range(0, 2) == 0);
                    rx_mode_left <= $urandom_range(10, 40);
                end
                else
                begin
                    rx_mode_left <= rx_mode_left - 1;
                end
                w = rx_calm ? 0 : $urandom_range(0, 13);
                if (w == 0)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    out_ready <= 1'b0;
                    rx_wait <= w - 1;
                end
            end
            else if (rx_wait > 0)
            begin
                out_ready <= 1'b0;
                rx_wait <= rx_wait - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor: the result is checked before the new word's expectation is queued.
    always @(posedge clk)
    begin
        vtdi_pkg::result_t exp_r;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            out_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            out_taken <= out_valid && out_ready;
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (slot_expect_q.size() == 0)
                begin
                    $error("unexpected result word: vertex_slot %0d was_new %0b overflow %0b",
                           vertex_slot, was_new, table_overflow);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = slot_expect_q.pop_front();
                    if (vertex_slot !== exp_r.slot)
                    begin
                        $error("vertex_slot: expected %0d, got %0d", exp_r.slot, vertex_slot);
                        mismatch_count++;
                    end
                    if (was_new !== exp_r.was_new)
                    begin
                        $error("was_new: expected %0b, got %0b", exp_r.was_new, was_new);
                        mismatch_count++;
                    end
                    if (table_overflow !== exp_r.overflow)
                    begin
                        $error("table_overflow: expected %0b, got %0b",
                               exp_r.overflow, table_overflow);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                slot_expect_q.insert(slot_expect_q.size(), predict_corner(
                    vtdi_pkg::triple_t'{position_index, texcoord_index, normal_index},
                    start_new_mesh));
            end
        end
    end

    initial
    begin
        vtdi_pkg::triple_t group_triples[$];
        vtdi_pkg::triple_t fill_triples[$];
        vtdi_pkg::triple_t tr;
        int      group_len;
        int      group_no;
        int      sel;
        int      bit_no;
        logic    narrow;
        logic    burst;
        logic    drain;
        logic    fresh;
        vtdi_pkg::index_t mask;

        // Directed words: the first one relies on the table being empty after reset.
        push_corner(vtdi_pkg::triple_t'{16'h0000, 16'h0000, 16'h0000}, 1'b0, 1'b0, 1'b1);
        push_corner(vtdi_pkg::triple_t'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, 1'b0, 1'b1);
        push_corner(vtdi_pkg::triple_t'{16'h0000, 16'h0000, 16'h0000}, 1'b0, 1'b0, 1'b1);
        push_corner(vtdi_pkg::triple_t'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, 1'b0, 1'b0);
        push_corner(vtdi_pkg::triple_t'{16'h0000, 16'h0000, 16'hFFFF}, 1'b0, 1'b0, 1'b0);
        push_corner(vtdi_pkg::triple_t'{16'h0000, 16'hFFFF, 16'h0000}, 1'b0, 1'b0, 1'b0);
        push_corner(vtdi_pkg::triple_t'{16'hFFFF, 16'h0000, 16'h0000}, 1'b0, 1'b0, 1'b0);
        push_corner(vtdi_pkg::triple_t'{16'hFFFF, 16'h0000, 16'h0000}, 1'b0, 1'b0, 1'b0);
        push_corner(vtdi_pkg::triple_t'{16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, 1'b0, 1'b0);
        push_corner(vtdi_pkg::triple_t'{16'h5555, 16'hAAAA, 16'h5555}, 1'b0, 1'b0, 1'b0);
        // A start flag on a triple already in the table still lands in slot 0.
        push_corner(vtdi_pkg::triple_t'{16'h5555, 16'hAAAA, 16'h5555}, 1'b1, 1'b0, 1'b0);
        push_corner(vtdi_pkg::triple_t'{16'h0000, 16'h0000, 16'h0000}, 1'b0, 1'b0, 1'b0);
        push_corner(vtdi_pkg::triple_t'{16'h0000, 16'h0000, 16'h0000}, 1'b1, 1'b0, 1'b1);
        push_corner(vtdi_pkg::triple_t'{16'h0000, 16'h0000, 16'h0000}, 1'b1, 1'b0, 1'b1);
        push_corner(vtdi_pkg::triple_t'{16'h5555, 16'hAAAA, 16'h5555}, 1'b0, 1'b0, 1'b0);

        // Random mesh groups, small enough that the search stays short.
        group_no = 0;
        while (corner_queue.size() < 300)
        begin
            group_len = $urandom_range(1, 40);
            burst = ($urandom_range(0, 3) == 0);
            drain = (group_no > 8) && ($urandom_range(0, 3) == 0);
            narrow = $urandom_range(0, 1);
            group_triples.delete();
            for (int i = 0; i < group_len; i++)
            begin
                sel = $urandom_range(0, 9);
                if (group_triples.size() != 0 && sel < 4)
                begin
                    tr = group_triples[$urandom_range(0, group_triples.size() - 1)];
                end
                else if (group_triples.size() != 0 && sel < 6)
                begin
                    // Near miss: one bit of one index differs from an earlier triple of the group.
                    tr = group_triples[$urandom_range(0, group_triples.size() - 1)];
                    bit_no = $urandom_range(0, vtdi_pkg::IndexBits - 1);
                    case ($urandom_range(0, 2))
                        0: tr.pos[bit_no] = ~tr.pos[bit_no];
                        1: tr.tex[bit_no] = ~tr.tex[bit_no];
                        default: tr.nrm[bit_no] = ~tr.nrm[bit_no];
                    endcase
                end
                else if (narrow)
                begin
                    tr = vtdi_pkg::triple_t'{vtdi_pkg::index_t'($urandom_range(0, 3)),
                                             vtdi_pkg::index_t'($urandom_range(0, 3)),
                                             vtdi_pkg::index_t'($urandom_range(0, 3))};
                end
                else
                begin
                    tr = vtdi_pkg::triple_t'{vtdi_pkg::index_t'($urandom),
                                             vtdi_pkg::index_t'($urandom),
                                             vtdi_pkg::index_t'($urandom)};
                end
                group_triples.insert(group_triples.size(), tr);
                fresh = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 31) == 0);
                push_corner(tr, fresh, drain && (i == 0), burst);
            end
            group_no++;
        end

        // One long group for deep searches; the texcoord index keeps triples distinct.
        mask = vtdi_pkg::index_t'($urandom);
        fill_triples.delete();
        while (fill_triples.size() < 240)
        begin
            burst = ((fill_triples.size() / 128) % 2) == 1;
            if (fill_triples.size() != 0 && $urandom_range(0, 7) == 0)
            begin
                tr = fill_triples[$urandom_range(0, fill_triples.size() - 1)];
                push_corner(tr, 1'b0, 1'b0, burst);
            end
            else
            begin
                tr = vtdi_pkg::triple_t'{vtdi_pkg::index_t'($urandom),
                                         vtdi_pkg::index_t'(fill_triples.size()) ^ mask,
                                         vtdi_pkg::index_t'($urandom)};
                push_corner(tr, fill_triples.size() == 0, fill_triples.size() == 0, burst);
                fill_triples.insert(fill_triples.size(), tr);
            end
        end
        push_corner(fill_triples[fill_triples.size() - 1], 1'b1, 1'b0, 1'b0);
        push_corner(fill_triples[0], 1'b0, 1'b0, 1'b0);
        push_corner(fill_triples[fill_triples.size() - 1], 1'b0, 1'b0, 1'b0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (corner_queue.size() != 0 || in_valid || slot_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (1100) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/vtdi_pkg.sv
rtl/vtdi_table.sv
rtl/vtdi_ctrl.sv
rtl/vertex_triple_dedup_indexer_core.sv
tb/sv/tb_top.sv
